>>> hw/rtl/i2a_pkg.sv
// Shared types, codes and character helpers for the integer-to-ASCII converter.
package i2a_pkg;

	// Number of digit cells: 20 decimal digits cover a 64-bit unsigned operand
	localparam int NUM_CELLS = 20;
	// Hex digits of a 64-bit operand
	localparam int HEX_DIGITS = 16;
	localparam int CNT_W = $clog2(NUM_CELLS + 1);

	// Conversion kinds
	localparam logic [1:0] OP_SDEC   = 2'd0;
	localparam logic [1:0] OP_UDEC   = 2'd1;
	localparam logic [1:0] OP_HEX    = 2'd2;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	// ASCII codes
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_ALPHA = 8'h57; // 'a' - 10
	localparam logic [7:0] CHAR_MINUS = 8'h2d;

	// Per-cycle operation of every digit cell
	typedef enum logic [1:0] {
		CM_HOLD,
		CM_LOAD,
		CM_CONV,
		CM_SHIFT
	} cell_mode_t;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CONV,
		ST_SKIP,
		ST_SIGN,
		ST_EMIT
	} state_t;

	// Sequencer control outputs
	typedef struct packed {
		cell_mode_t mode;
		logic       in_stall;
		logic       load_out;
		logic       sel_minus;
		logic       cnt_dec;
		logic       conv_step;
	} ctl_t;

	// Shift-and-add-3 correction of one BCD digit
	function automatic logic [3:0] adj3(input logic [3:0] d);
		return (d >= 4'd5) ? d + 4'd3 : d;
	endfunction

	// ASCII code of one digit, 0-9 then a-f
	function automatic logic [7:0] digit_char(input logic [3:0] d);
		return (d < 4'd10) ? CHAR_ZERO + {4'b0, d} : CHAR_ALPHA + {4'b0, d};
	endfunction

endpackage

>>> hw/rtl/integer_to_ascii_digits_unit.sv
// Top level of the integer-to-ASCII converter: sequencer, operand register, digit chain.
//
// Input channel: in_valid/in_stall with op, wide and value. Output channel:
// out_valid/out_stall with char_out and last, one character per transaction,
// most significant first, last set on the final character.
// One number is converted at a time. After acceptance, decimal kinds run the
// 32- or 64-bit operand through the row of 20 digit cells two bits per cycle.
// Hex loads the nibbles straight into the cells. Leading zeros are then
// shifted out of the top cell, one per cycle (at most 19), and the sequencer
// stops at the first nonzero digit or at the last cell. A minus sign goes to
// the output register first, then the digits, taken from the top cell.
// The output register lets the next item be accepted while the final
// character still waits. A stalled receiver holds the output register and,
// while characters go out, the chain. An item with the unused kind is
// accepted and produces nothing. Reset clears the sequencer and the output
// valid; no item is in flight.
module integer_to_ascii_digits_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  op,
	input  logic        wide,
	input  logic [63:0] value,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  char_out,
	output logic        last
);
	import i2a_pkg::*;

	state_t           state_q;
	state_t           state_d;
	ctl_t             ctl;
	logic [63:0]      mag_q;
	logic [4:0]       conv_cnt_q;
	logic [CNT_W-1:0] cnt_q;
	logic             minus_q;
	logic             out_valid_q;
	logic [7:0]       char_q;
	logic             last_q;

	logic             in_acc;
	logic             out_free;
	logic             neg;
	logic [63:0]      sx;
	logic [63:0]      mag_dec;
	logic [63:0]      mag_raw;
	logic [63:0]      conv_src;
	logic             top_zero;
	logic             skip_move;
	logic             cnt_one;

	logic [3:0] digits   [NUM_CELLS];
	logic [3:0] load_dig [NUM_CELLS];
	logic [1:0] bits     [NUM_CELLS];

	assign in_acc   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	// Operand forms: sign, sign-extended, magnitude and raw zero-extended
	always_comb begin
		neg      = wide ? value[63] : value[31];
		sx       = wide ? value : {{32{value[31]}}, value[31:0]};
		mag_raw  = wide ? value : {32'b0, value[31:0]};
		mag_dec  = (op == OP_SDEC && neg) ? (64'd0 - sx) : mag_raw;
		conv_src = wide ? mag_dec : {mag_dec[31:0], 32'b0};
	end

	assign top_zero  = (digits[NUM_CELLS-1] == 4'd0);
	assign cnt_one   = (cnt_q == CNT_W'(1));
	assign skip_move = top_zero && !cnt_one;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					unique case (op) inside
						OP_SDEC, OP_UDEC: state_d = ST_CONV;
						OP_HEX:           state_d = ST_SKIP;
						default:          state_d = ST_IDLE;
					endcase
				end
			end
			ST_CONV: begin
				if (conv_cnt_q == 5'd0) state_d = ST_SKIP;
			end
			ST_SKIP: begin
				if (!skip_move) state_d = minus_q ? ST_SIGN : ST_EMIT;
			end
			ST_SIGN: begin
				if (out_free) state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (out_free && cnt_one) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Sequencer outputs
	always_comb begin
		ctl = '0;
		ctl.mode = CM_HOLD;
		ctl.in_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				ctl.in_stall = 1'b0;
				ctl.mode     = in_valid ? CM_LOAD : CM_HOLD;
			end
			ST_CONV: begin
				ctl.mode      = CM_CONV;
				ctl.conv_step = 1'b1;
			end
			ST_SKIP: begin
				ctl.mode    = skip_move ? CM_SHIFT : CM_HOLD;
				ctl.cnt_dec = skip_move;
			end
			ST_SIGN: begin
				ctl.load_out  = out_free;
				ctl.sel_minus = 1'b1;
			end
			ST_EMIT: begin
				ctl.mode     = out_free ? CM_SHIFT : CM_HOLD;
				ctl.load_out = out_free;
				ctl.cnt_dec  = out_free;
			end
			default: ctl.in_stall = 1'b1;
		endcase
	end

	assign in_stall = ctl.in_stall;

	// Hold sequencer state, counters and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			conv_cnt_q  <= '0;
			cnt_q       <= '0;
			minus_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (in_acc) begin
				conv_cnt_q <= wide ? 5'd31 : 5'd15;
				cnt_q      <= CNT_W'(NUM_CELLS);
				minus_q    <= (op == OP_SDEC) && neg;
			end else begin
				if (ctl.conv_step) conv_cnt_q <= conv_cnt_q - 5'd1;
				if (ctl.cnt_dec)   cnt_q      <= cnt_q - CNT_W'(1);
			end
		end
	end

	// Operand shift register feeding the bottom cell, two bits a cycle
	always_ff @(posedge clk) begin
		if (in_acc) begin
			mag_q <= conv_src;
		end else if (ctl.conv_step) begin
			mag_q <= {mag_q[61:0], 2'b00};
		end
	end

	// Output register
	always_ff @(posedge clk) begin
		if (ctl.load_out) begin
			char_q <= ctl.sel_minus ? CHAR_MINUS : digit_char(digits[NUM_CELLS-1]);
			last_q <= ctl.sel_minus ? 1'b0 : cnt_one;
		end
	end

	assign out_valid = out_valid_q;
	assign char_out  = char_q;
	assign last      = last_q;

	// Row of digit cells, cell 0 at the bottom
	for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
		if (i < HEX_DIGITS) begin : g_hex
			assign load_dig[i] = (op == OP_HEX) ? mag_raw[4*i +: 4] : 4'd0;
		end else begin : g_dec
			assign load_dig[i] = 4'd0;
		end

		if (i == 0) begin : g_bot
			i2a_cell u_cell (
				.clk        (clk),
				.mode       (ctl.mode),
				.load_digit (load_dig[i]),
				.bits_in    (mag_q[63:62]),
				.digit_in   (4'd0),
				.digit      (digits[i]),
				.bits_out   (bits[i])
			);
		end else begin : g_mid
			i2a_cell u_cell (
				.clk        (clk),
				.mode       (ctl.mode),
				.load_digit (load_dig[i]),
				.bits_in    (bits[i-1]),
				.digit_in   (digits[i-1]),
				.digit      (digits[i]),
				.bits_out   (bits[i])
			);
		end
	end

endmodule

>>> hw/rtl/i2a_cell.sv
// One digit cell: holds a 4-bit digit, converts two bits per cycle, shifts toward the top.
module i2a_cell (
	input  logic                clk,
	input  i2a_pkg::cell_mode_t mode,
	input  logic [3:0]          load_digit,
	input  logic [1:0]          bits_in,
	input  logic [3:0]          digit_in,
	output logic [3:0]          digit,
	output logic [1:0]          bits_out
);
	import i2a_pkg::*;

	logic [3:0] digit_q;
	logic [3:0] a1;
	logic [3:0] mid;
	logic [3:0] a2;
	logic [3:0] conv_next;

	// Two double-dabble steps: correct, shift in the neighbor's bit, repeat
	always_comb begin
		a1        = adj3(digit_q);
		mid       = {a1[2:0], bits_in[1]};
		a2        = adj3(mid);
		conv_next = {a2[2:0], bits_in[0]};
		bits_out  = {a1[3], a2[3]};
	end

	// Update the held digit
	always_ff @(posedge clk) begin
		unique case (mode)
			CM_LOAD:  digit_q <= load_digit;
			CM_CONV:  digit_q <= conv_next;
			CM_SHIFT: digit_q <= digit_in;
			default:  digit_q <= digit_q;
		endcase
	end

	assign digit = digit_q;

endmodule

>>> hw/rtl/i2a_checker.sv
// Port-level checks of the integer-to-ASCII converter and their binding to the top level.
module i2a_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic [1:0]  op,
	input logic        out_valid,
	input logic        out_stall,
	input logic [7:0]  char_out,
	input logic        last
);
	import i2a_pkg::*;

	// Hold a stalled output transaction unchanged
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(char_out) && $stable(last))
		else $error("stalled output transaction changed");

	// Emit only digits, a-f or minus
	a_char_legal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((char_out >= 8'h30 && char_out <= 8'h39) ||
		               (char_out >= 8'h61 && char_out <= 8'h66) ||
		               char_out == CHAR_MINUS))
		else $error("illegal output character");

	// A minus sign never ends a number
	a_minus_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && char_out == CHAR_MINUS |-> !last)
		else $error("minus sign flagged as last");

	// Stall the input while a number is being converted
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && op != OP_UNUSED |=> in_stall)
		else $error("input accepted while a number is in progress");

endmodule

bind integer_to_ascii_digits_unit i2a_checker u_i2a_checker (.*);

>>> tb/testbench.sv
// Self-checking testbench for the integer-to-ASCII converter.
`timescale 1ns / 100ps

module testbench;
	import i2a_pkg::*;

	localparam logic [8*16-1:0] DIGIT_TEXT = "0123456789abcdef";
	localparam int RANDOM_ITEMS = 75;
	localparam int PAUSE_AFTER = 50;
	localparam int RX_LONG_HOLD = 400;
	localparam int DRAIN_CYCLES = 100;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int REPORT_LIMIT = 10;

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
	} text_char_t;

	typedef struct {
		logic [1:0]  kind;
		logic        w;
		logic [63:0] v;
		string       text;
	} number_case_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  op = OP_SDEC;
	logic        wide = 1'b0;
	logic [63:0] value = 64'd0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [7:0]  char_out;
	logic        last;

	text_char_t  pending_chars[$];
	text_char_t  want;
	int          error_count = 0;
	int          chars_seen = 0;
	int          idle_cycles = 0;
	bit          long_hold_done = 1'b0;
	bit          tx_no_gaps = 1'b0;

	// An empty text means the row is checked against the predictor
	number_case_t directed_cases[25] = '{
		'{OP_SDEC,   1'b1, 64'h0000000000000000, "0"},
		'{OP_SDEC,   1'b0, 64'hffffffff00000000, "0"},
		'{OP_SDEC,   1'b1, 64'h8000000000000000, "-9223372036854775808"},
		'{OP_SDEC,   1'b0, 64'h0000000080000000, "-2147483648"},
		'{OP_SDEC,   1'b1, 64'h7fffffffffffffff, "9223372036854775807"},
		'{OP_SDEC,   1'b0, 64'h000000007fffffff, "2147483647"},
		'{OP_SDEC,   1'b1, 64'hffffffffffffffff, "-1"},
		'{OP_SDEC,   1'b0, 64'h12345678ffffffff, "-1"},
		'{OP_UDEC,   1'b1, 64'hffffffffffffffff, "18446744073709551615"},
		'{OP_UDEC,   1'b0, 64'hffffffffffffffff, "4294967295"},
		'{OP_UDEC,   1'b1, 64'h0000000000000000, "0"},
		'{OP_UDEC,   1'b0, 64'hffffffff00000009, "9"},
		'{OP_HEX,    1'b1, 64'h0000000000000000, "0"},
		'{OP_HEX,    1'b1, 64'h8000000000000000, "8000000000000000"},
		'{OP_HEX,    1'b0, 64'h0000000080000000, "80000000"},
		'{OP_HEX,    1'b1, 64'hffffffffffffffff, "ffffffffffffffff"},
		'{OP_HEX,    1'b0, 64'habcdef01fffffffe, "fffffffe"},
		'{OP_HEX,    1'b1, 64'h7fffffffffffffff, "7fffffffffffffff"},
		'{OP_HEX,    1'b0, 64'h800000000000000a, "a"},
		'{OP_HEX,    1'b1, 64'h0123456789abcdef, ""},
		'{OP_UNUSED, 1'b1, 64'h5a5a5a5a5a5a5a5a, ""},
		'{OP_SDEC,   1'b1, 64'h00000000499602d2, ""},
		'{OP_UDEC,   1'b1, 64'h8ac7230489e80000, ""},
		'{OP_SDEC,   1'b0, 64'hffffffff7fffffff, ""},
		'{OP_HEX,    1'b0, 64'h000000007fffffff, ""}
	};

	integer_to_ascii_digits_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.op        (op),
		.wide      (wide),
		.value     (value),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.char_out  (char_out),
		.last      (last)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Append the expected text of one number, most significant character first
	function automatic void spell_number(input logic [1:0] kind, input logic w,
			input logic [63:0] raw);
		logic [7:0]  rev[20];
		logic [63:0] sx;
		logic [63:0] mag;
		logic        neg;
		logic        minus;
		int          n;
		int          i;
		int          d;
		n = 0;
		minus = 1'b0;
		neg = w ? raw[63] : raw[31];
		sx = w ? raw : {{32{raw[31]}}, raw[31:0]};
		mag = w ? raw : {32'd0, raw[31:0]};
		case (kind) inside
			OP_SDEC, OP_UDEC: begin
				if (kind == OP_SDEC) begin
					minus = neg;
					mag = neg ? -sx : sx;
				end
				while (1) begin
					d = int'(mag % 64'd10);
					rev[n] = DIGIT_TEXT[8*(15-d) +: 8];
					n++;
					mag = mag / 64'd10;
					if (mag == 64'd0) break;
				end
			end
			OP_HEX: begin
				// Negative hex keeps every nibble of the selected width
				while (1) begin
					d = int'(mag[3:0]);
					rev[n] = DIGIT_TEXT[8*(15-d) +: 8];
					n++;
					mag = mag >> 4;
					if (neg ? (n == (w ? 16 : 8)) : (mag == 64'd0)) break;
				end
			end
			default: return;
		endcase
		if (minus)
			pending_chars.push_back('{ch: CHAR_MINUS, last: 1'b0});
		for (i = n - 1; i >= 0; i--)
			pending_chars.push_back('{ch: rev[i], last: (i == 0)});
	endfunction

	// Mostly short gaps, a few long ones
	function automatic int idle_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Draw an operand from a mix of small, boundary and full-range values
	function automatic logic [63:0] random_operand();
		logic [63:0] v;
		logic [63:0] p;
		v = {$urandom(), $urandom()};
		case ($urandom_range(0, 9))
			0: v = 64'($urandom_range(0, 20));
			1: v = -64'($urandom_range(1, 20));
			2: begin
				p = 64'd1;
				repeat ($urandom_range(0, 19)) p = p * 64'd10;
				v = p + 64'($urandom_range(0, 2)) - 64'd1;
				if ($urandom_range(0, 1) == 1) v = -v;
			end
			3: v = v >> $urandom_range(0, 63);
			4: begin
				case ($urandom_range(0, 3))
					0: v[31:0] = 32'h7fffffff;
					1: v[31:0] = 32'h80000000;
					2: v[31:0] = 32'hffffffff;
					default: v[31:0] = 32'h00000000;
				endcase
			end
			5: begin
				case ($urandom_range(0, 3))
					0: v = 64'h7fffffffffffffff;
					1: v = 64'h8000000000000000;
					2: v = 64'hffffffffffffffff;
					default: v = 64'h8000000000000001;
				endcase
			end
			default: ;
		endcase
		return v;
	endfunction

	// Offer one number and record its expected text once the transaction completes
	task automatic offer_number(input logic [1:0] kind, input logic w, input logic [63:0] v,
			input string text);
		int gap;
		int i;
		gap = tx_no_gaps ? 0 : idle_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		op <= kind;
		wide <= w;
		value <= v;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		if (text.len() == 0)
			spell_number(kind, w, v);
		else
			for (i = 0; i < text.len(); i++)
				pending_chars.push_back('{ch: text[i], last: (i == text.len() - 1)});
	endtask

	// Stimulus: reset, directed table, then random numbers
	initial begin
		logic [1:0] kind;
		int         counted;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed_cases[k])
			offer_number(directed_cases[k].kind, directed_cases[k].w, directed_cases[k].v,
				directed_cases[k].text);
		counted = 0;
		while (counted < RANDOM_ITEMS) begin
			// Run about one group of ten in four back to back
			if (counted % 10 == 0)
				tx_no_gaps = ($urandom_range(0, 3) == 0);
			if (counted == PAUSE_AFTER) begin
				in_valid <= 1'b0;
				do @(posedge clk); while (pending_chars.size() != 0);
			end
			kind = ($urandom_range(0, 19) == 0) ? OP_UNUSED : 2'($urandom_range(0, 2));
			offer_number(kind, 1'($urandom_range(0, 1)), random_operand(), "");
			if (kind != OP_UNUSED) counted++;
		end
		in_valid <= 1'b0;
		while (pending_chars.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("integer_to_ascii_digits_unit verification clean");
		else
			$display("integer_to_ascii_digits_unit verification failed");
		$finish;
	end

	// Receiver: random stalls, plus one long hold-off to back the block up
	initial begin
		int stall_len;
		@(posedge clk);
		forever begin
			if (!long_hold_done && chars_seen >= 40) begin
				out_stall <= 1'b1;
				repeat (RX_LONG_HOLD) @(posedge clk);
				long_hold_done = 1'b1;
			end
			out_stall <= 1'b0;
			repeat ($urandom_range(1, 40)) @(posedge clk);
			stall_len = idle_gap();
			if (stall_len > 0) begin
				out_stall <= 1'b1;
				repeat (stall_len) @(posedge clk);
			end
		end
	end

	// Check each character against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			chars_seen++;
			if (pending_chars.size() == 0) begin
				error_count++;
				if (error_count <= REPORT_LIMIT)
					$display("unexpected character %02h last %0d", char_out, last);
			end else begin
				want = pending_chars.pop_front();
				if (char_out !== want.ch || last !== want.last) begin
					error_count++;
					if (error_count <= REPORT_LIMIT)
						$display("mismatch: expected %02h last %0d, got %02h last %0d",
							want.ch, want.last, char_out, last);
				end
			end
		end
	end

	// Watchdog: end the run when no transaction moves for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("integer_to_ascii_digits_unit verification failed");
				$finish;
			end
		end
	end

endmodule
